// File: sv/rbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the RMS box downscaler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Pixel format.
  localparam int NUM_CH = 3;
  localparam int CH_W   = 8;
  localparam int SQ_W   = 2 * CH_W;

  // Configuration port.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int KREG_W    = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FACTOR = 2'd2;

  localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
  localparam logic [KREG_W-1:0] RST_BLOCK_FACTOR = 5'd2;

  // Tallest frame supported.
  localparam int MAX_HEIGHT = 4096;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the input pixel and advance the position
    logic wr_sum;    // update the column store with the new square sum
    logic sq_start;  // start the root search
    logic sq_mul;    // square the trial roots
    logic sq_cmp;    // compare scaled squares against the sums
    logic load_out;  // move the roots to the output register
  } rbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pix_valid; // next pixel lies inside a whole block
    logic fire;      // pixel in flight completes a block
    logic sq_last;   // root search is on its last bit
    logic out_busy;  // output register holds an untaken result
  } rbd_sts_t;

endpackage

// File: sv/rbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ctrl
// Controller: sequences store update, root search and output load per pixel.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rbd_pkg::rbd_sts_t sts,
  output rbd_pkg::rbd_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && sts.pix_valid) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.wr_sum   = 1'b1;
        cmd.sq_start = 1'b1;
        state_nxt    = sts.fire ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.sq_mul = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.sq_cmp = 1'b1;
        state_nxt  = sts.sq_last ? S_LOAD : S_MUL;
      end
      S_LOAD: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/rbd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_dpath
// Datapath: position counters, column square-sum stores and root search.
// ----------------------------------------------------------------------------
module rbd_dpath #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rbd_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic [rbd_pkg::NUM_CH*rbd_pkg::CH_W-1:0] pix,
  input  rbd_pkg::rbd_cmd_t                    cmd,
  output rbd_pkg::rbd_sts_t                    sts,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [rbd_pkg::NUM_CH*rbd_pkg::CH_W-1:0] out_pix,
  output logic                                 out_row_end,
  output logic                                 out_frame_end
);

  localparam int KW    = $clog2(MAX_FACTOR + 1);
  localparam int NW    = 2 * KW;
  localparam int SUM_W = rbd_pkg::SQ_W + 2 * $clog2(MAX_FACTOR);
  localparam int PW    = rbd_pkg::SQ_W + NW;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int XW    = $clog2(MAX_WIDTH + 2 * MAX_FACTOR + 1);
  localparam int YW    = $clog2(rbd_pkg::MAX_HEIGHT + 2 * MAX_FACTOR + 1);
  localparam int CH    = rbd_pkg::NUM_CH;
  localparam int CW    = rbd_pkg::CH_W;

  // Configuration registers.
  logic [rbd_pkg::CFG_W-1:0]  fw_r, fh_r;
  logic [rbd_pkg::KREG_W-1:0] fk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= rbd_pkg::RST_FRAME_WIDTH;
      fh_r <= rbd_pkg::RST_FRAME_HEIGHT;
      fk_r <= rbd_pkg::RST_BLOCK_FACTOR;
    end else if (cfg_we) begin
      case (cfg_index)
        rbd_pkg::CFG_FRAME_WIDTH:  fw_r <= cfg_wdata;
        rbd_pkg::CFG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        rbd_pkg::CFG_BLOCK_FACTOR: fk_r <= cfg_wdata[rbd_pkg::KREG_W-1:0];
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we && (cfg_index == rbd_pkg::CFG_FRAME_WIDTH ||
                              cfg_index == rbd_pkg::CFG_FRAME_HEIGHT ||
                              cfg_index == rbd_pkg::CFG_BLOCK_FACTOR);

  // Clamped working sizes.
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [KW-1:0] k_eff;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = XW'(1);
    end else if (XW'(fw_r) > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(fw_r);
    end
    if (fh_r == '0) begin
      h_eff = YW'(1);
    end else if (YW'(fh_r) > YW'(rbd_pkg::MAX_HEIGHT)) begin
      h_eff = YW'(rbd_pkg::MAX_HEIGHT);
    end else begin
      h_eff = YW'(fh_r);
    end
    if (fk_r == '0) begin
      k_eff = KW'(1);
    end else if ((KW + rbd_pkg::KREG_W)'(fk_r) > (KW + rbd_pkg::KREG_W)'(MAX_FACTOR)) begin
      k_eff = KW'(MAX_FACTOR);
    end else begin
      k_eff = KW'(fk_r);
    end
  end

  // Position counters. The block bases are the first column and row of the
  // current block, so a block is whole when base plus k fits in the frame.
  logic [XW-1:0] pcol_r, pcol_nxt, cbase_r, cbase_nxt;
  logic [YW-1:0] prow_r, prow_nxt, rbase_r, rbase_nxt;
  logic [KW-1:0] cib_r, cib_nxt, rib_r, rib_nxt;
  logic [AW-1:0] bcol_r, bcol_nxt;

  logic pix_valid, first, fire, last_col, last_row;

  always_comb begin
    pix_valid = ((cbase_r + XW'(k_eff)) <= w_eff) && ((rbase_r + YW'(k_eff)) <= h_eff);
    first     = (cib_r == '0) && (rib_r == '0);
    fire      = (cib_r == k_eff - KW'(1)) && (rib_r == k_eff - KW'(1));
    last_col  = (cbase_r + XW'(k_eff) + XW'(k_eff)) > w_eff;
    last_row  = (rbase_r + YW'(k_eff) + YW'(k_eff)) > h_eff;
  end

  always_comb begin
    pcol_nxt  = pcol_r;
    prow_nxt  = prow_r;
    cib_nxt   = cib_r;
    rib_nxt   = rib_r;
    bcol_nxt  = bcol_r;
    cbase_nxt = cbase_r;
    rbase_nxt = rbase_r;
    if (cfg_hit) begin
      pcol_nxt  = '0;
      prow_nxt  = '0;
      cib_nxt   = '0;
      rib_nxt   = '0;
      bcol_nxt  = '0;
      cbase_nxt = '0;
      rbase_nxt = '0;
    end else if (cmd.accept) begin
      if (pix_valid) begin
        if (cib_r + KW'(1) >= k_eff) begin
          cib_nxt   = '0;
          bcol_nxt  = bcol_r + AW'(1);
          cbase_nxt = cbase_r + XW'(k_eff);
        end else begin
          cib_nxt = cib_r + KW'(1);
        end
      end
      if (pcol_r + XW'(1) >= w_eff) begin
        pcol_nxt  = '0;
        cib_nxt   = '0;
        bcol_nxt  = '0;
        cbase_nxt = '0;
        if (rib_r + KW'(1) >= k_eff) begin
          rib_nxt   = '0;
          rbase_nxt = rbase_r + YW'(k_eff);
        end else begin
          rib_nxt = rib_r + KW'(1);
        end
        if (prow_r + YW'(1) >= h_eff) begin
          prow_nxt  = '0;
          rib_nxt   = '0;
          rbase_nxt = '0;
        end else begin
          prow_nxt = prow_r + YW'(1);
        end
      end else begin
        pcol_nxt = pcol_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcol_r  <= '0;
      prow_r  <= '0;
      cib_r   <= '0;
      rib_r   <= '0;
      bcol_r  <= '0;
      cbase_r <= '0;
      rbase_r <= '0;
    end else begin
      pcol_r  <= pcol_nxt;
      prow_r  <= prow_nxt;
      cib_r   <= cib_nxt;
      rib_r   <= rib_nxt;
      bcol_r  <= bcol_nxt;
      cbase_r <= cbase_nxt;
      rbase_r <= rbase_nxt;
    end
  end

  // Pixel capture: squares, block flags and the store address.
  logic [rbd_pkg::SQ_W-1:0] sq_r [CH];
  logic                     first_r, fire_r, last_col_r, last_row_r;
  logic [AW-1:0]            addr_r;
  logic [NW-1:0]            n_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int c = 0; c < CH; c++) begin
        sq_r[c] <= pix[c*CW +: CW] * pix[c*CW +: CW];
      end
      first_r    <= first;
      fire_r     <= fire;
      last_col_r <= last_col;
      last_row_r <= last_row;
      addr_r     <= bcol_r;
      n_r        <= NW'(k_eff) * NW'(k_eff);
    end
  end

  // Column stores and square-sum update.
  logic [SUM_W-1:0] rd_sum [CH];
  logic [SUM_W-1:0] new_sum [CH];
  logic [SUM_W-1:0] sum_r [CH];

  for (genvar c = 0; c < CH; c++) begin : g_store
    assign new_sum[c] = first_r ? SUM_W'(sq_r[c]) : rd_sum[c] + SUM_W'(sq_r[c]);

    rbd_ram #(
      .WIDTH(SUM_W),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (cmd.wr_sum),
      .waddr (addr_r),
      .wdata (new_sum[c]),
      .re    (cmd.accept && pix_valid),
      .raddr (bcol_r),
      .rdata (rd_sum[c])
    );
  end

  // Root search: one result bit per square and compare pair.
  logic [CW-1:0]            bit_r;
  logic [CW-1:0]            root_r [CH];
  logic [rbd_pkg::SQ_W-1:0] tt_r [CH];

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      bit_r <= CW'(1) << (CW - 1);
      for (int c = 0; c < CH; c++) begin
        root_r[c] <= '0;
        sum_r[c]  <= new_sum[c];
      end
    end else if (cmd.sq_mul) begin
      for (int c = 0; c < CH; c++) begin
        tt_r[c] <= (root_r[c] | bit_r) * (root_r[c] | bit_r);
      end
    end else if (cmd.sq_cmp) begin
      for (int c = 0; c < CH; c++) begin
        if (PW'(tt_r[c]) * PW'(n_r) <= PW'(sum_r[c])) begin
          root_r[c] <= root_r[c] | bit_r;
        end
      end
      bit_r <= bit_r >> 1;
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int c = 0; c < CH; c++) begin
        out_pix[c*CW +: CW] <= root_r[c];
      end
      out_row_end   <= last_col_r;
      out_frame_end <= last_col_r && last_row_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign sts.pix_valid = pix_valid;
  assign sts.fire      = fire_r;
  assign sts.sq_last   = bit_r[0];
  assign sts.out_busy  = out_valid_r && !out_tready;

endmodule

// File: sv/rms_box_downscale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_box_downscale
// RMS box-filter downscaler for RGB pixel streams in raster order.
// ----------------------------------------------------------------------------
// Each pixel inside a whole k-by-k block is accepted, then its column entry
// in the square-sum store gets a read-modify-write; a pixel outside every
// whole block is only accepted. A block's last pixel adds the root search,
// a square step and a compare step per result bit, and then a load of the
// output register, before the next pixel is accepted. The load waits, and
// the input with it, while the previous result still sits untaken in the
// output register. A finished result waits in the output register while the
// next pixels stream in. The stores need no clearing, since each block's first
// pixel overwrites its entry. A write to any register restarts the frame.
module rms_box_downscale #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [rbd_pkg::CFG_W-1:0]                cfg_wdata,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // Fields from bit 0: in_red, in_green, in_blue.
  input  logic [rbd_pkg::NUM_CH*rbd_pkg::CH_W-1:0] in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // Fields from bit 0: out_red, out_green, out_blue.
  output logic [rbd_pkg::NUM_CH*rbd_pkg::CH_W-1:0] out_tdata,
  // Fields from bit 0: row_end.
  output logic                                     out_tuser,
  output logic                                     out_tlast
);

  rbd_pkg::rbd_cmd_t cmd;
  rbd_pkg::rbd_sts_t sts;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rbd_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .pix           (in_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_pix       (out_tdata),
    .out_row_end   (out_tuser),
    .out_frame_end (out_tlast)
  );

endmodule

// File: sim/rms_box_downscale_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_box_downscale_tb
// Self-checking testbench for the RMS box-filter downscaler.
// ----------------------------------------------------------------------------
// Small frames stream through the block under several geometries and idle
// patterns. A block-sum model predicts each output pixel, and a scoreboard
// compares every output transaction with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module rms_box_downscale_tb;

  localparam int MAX_WIDTH_C = 4096;

  // Register index that maps to no register.
  localparam logic [1:0] CFG_NO_REG = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } out_pix_t;

  // Predicted pixels and the model state that produces them.
  class rms_scoreboard;
    out_pix_t    pending[$];
    int unsigned width, height, factor;
    int unsigned col, row, cib, rib, bcol;
    int unsigned rsum[MAX_WIDTH_C], gsum[MAX_WIDTH_C], bsum[MAX_WIDTH_C];
    int          errors;

    function new();
      width = 640; height = 480; factor = 2; errors = 0;
      restart();
    endfunction

    function void restart();
      col = 0; row = 0; cib = 0; rib = 0; bcol = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // Largest root r with r*r*n <= s.
    function logic [7:0] block_root(longint unsigned s, longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int b = 7; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t * n <= s) r = t;
      end
      return r[7:0];
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        rbd_pkg::CFG_FRAME_WIDTH:  width = val;
        rbd_pkg::CFG_FRAME_HEIGHT: height = val;
        rbd_pkg::CFG_BLOCK_FACTOR: factor = val[4:0];
        default: return;
      endcase
      restart();
    endfunction

    function void note_pixel(logic [23:0] d);
      int unsigned w, h, k, ow, oh, r, g, b;
      out_pix_t p;
      w = clamp(width, MAX_WIDTH_C); h = clamp(height, 4096); k = clamp(factor, 16);
      ow = w / k; oh = h / k;
      r = d[7:0]; g = d[15:8]; b = d[23:16];
      if (col < ow * k && row < oh * k) begin
        if (cib == 0 && rib == 0) begin
          rsum[bcol] = r * r; gsum[bcol] = g * g; bsum[bcol] = b * b;
        end else begin
          rsum[bcol] += r * r; gsum[bcol] += g * g; bsum[bcol] += b * b;
        end
        if (cib == k - 1 && rib == k - 1) begin
          p.red = block_root(rsum[bcol], k * k);
          p.green = block_root(gsum[bcol], k * k);
          p.blue = block_root(bsum[bcol], k * k);
          p.row_end = (bcol == ow - 1);
          p.frame_end = p.row_end && (row == oh * k - 1);
          pending.push_back(p);
        end
        cib++;
        if (cib >= k) begin
          cib = 0; bcol++;
        end
      end
      col++;
      if (col >= w) begin
        col = 0; cib = 0; bcol = 0; rib++;
        if (rib >= k) rib = 0;
        row++;
        if (row >= h) begin
          row = 0; rib = 0;
        end
      end
    endfunction

    function void check_pixel(logic [23:0] d, logic re, logic fe);
      out_pix_t p;
      if (pending.size() == 0) begin
        $error("unexpected output transaction, data %h", d);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (d[7:0] !== p.red) begin
        $error("out_red expected %0d actual %0d", p.red, d[7:0]); errors++;
      end
      if (d[15:8] !== p.green) begin
        $error("out_green expected %0d actual %0d", p.green, d[15:8]); errors++;
      end
      if (d[23:16] !== p.blue) begin
        $error("out_blue expected %0d actual %0d", p.blue, d[23:16]); errors++;
      end
      if (re !== p.row_end) begin
        $error("row_end expected %0b actual %0b", p.row_end, re); errors++;
      end
      if (fe !== p.frame_end) begin
        $error("frame_end expected %0b actual %0b", p.frame_end, fe); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // red, green, blue from bit 0
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // red, green, blue from bit 0
  logic        out_tuser;       // row_end
  logic        out_tlast;

  rms_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;
  int  quiet_cycles = 0;

  localparam int QUIET_LIMIT = 20000;

  always #6 clk = ~clk;

  rms_box_downscale DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_pixel(out_tdata, out_tuser, out_tlast);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One register write, after which the write enable is driven low again.
  task automatic write_cfg(logic [1:0] idx, logic [12:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Offers one pixel after an optional random gap and waits for acceptance.
  task automatic send_pixel(logic [23:0] d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(d);
  endtask

  task automatic finish_sending();
    in_tvalid <= 1'b0;
  endtask

  // Waits until every predicted pixel has been taken, then lets the block
  // settle.
  task automatic drain();
    finish_sending();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned k);
    write_cfg(rbd_pkg::CFG_FRAME_WIDTH, 13'(w));
    write_cfg(rbd_pkg::CFG_FRAME_HEIGHT, 13'(h));
    write_cfg(rbd_pkg::CFG_BLOCK_FACTOR, 13'(k));
  endtask

  task automatic send_frames(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_pixel(24'($urandom()));
  endtask

  initial begin
    int unsigned w, h, k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme values in one 2x2 geometry with partial blocks.
    set_geometry(5, 3, 2);
    send_pixel(24'hFFFFFF); send_pixel(24'h000000); send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00); send_pixel(24'h123456);
    send_pixel(24'hFFFFFF); send_pixel(24'hFFFFFF); send_pixel(24'h00FF00);
    send_pixel(24'hFF00FF); send_pixel(24'hABCDEF);
    send_frames(5);
    drain();
    // Factor one passes pixels through; frame smaller than one block yields none.
    set_geometry(3, 2, 1);
    send_frames(6);
    drain();
    set_geometry(3, 20, 4);
    send_frames(8);
    drain();
    // Register edge cases: unknown index ignored, zero factor clamped, largest factor.
    write_cfg(CFG_NO_REG, 13'h1FFF);
    set_geometry(2, 2, 0);
    send_frames(4);
    drain();
    set_geometry(16, 16, 16);
    for (int i = 0; i < 256; i++) send_pixel(24'hFFFFFF);
    drain();

    // Random phases over idle patterns and geometries.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      k = (ph == 7) ? 16 : $urandom_range(1, 4);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      if (ph == 7) begin
        w = 17; h = 16;
      end
      if (ph == 6) h = 1;
      set_geometry(w, h, k);
      if (ph == 0) hold_off <= 300;
      send_frames(150 + $urandom_range(0, 60));
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    set_geometry(8191, 8191, 31);
    drain();

    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
